// ----- hdl/fas_pkg.sv -----
package fas_pkg;

    localparam int OPERAND_WIDTH_DEF = 16;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_GCD_TEST,
        ST_GCD_WAIT,
        ST_Q1_WAIT,
        ST_Q2_WAIT,
        ST_MUL_L,
        ST_MUL_T1,
        ST_MUL_T2,
        ST_SUM,
        ST_DONE
    } fas_state_t;

    typedef enum logic [1:0] {
        DIV_GCD,
        DIV_Q1,
        DIV_Q2
    } fas_div_sel_t;

    typedef enum logic [1:0] {
        MUL_L,
        MUL_T1,
        MUL_T2
    } fas_mul_sel_t;

    typedef struct packed {
        logic         load;
        logic         fail;
        logic         div_start;
        fas_div_sel_t div_sel;
        logic         gcd_step;
        logic         q1_latch;
        logic         q2_latch;
        logic         mul_en;
        fas_mul_sel_t mul_sel;
        logic         sum;
    } fas_cmd_t;

    typedef struct packed {
        logic den_zero;
        logic b_zero;
        logic div_done;
    } fas_status_t;

endpackage

// ----- hdl/fraction_add_subtract.sv -----
// Adds or subtracts two signed fractions over the common denominator
// l = d1*d2/g without reducing the result; g comes from a Euclid loop and
// is negative only when d2 is negative and divides d1 exactly. A zero
// denominator gives status 1 with both result fields zero. One item is
// worked at a time: a shared radix-2 divider is used once per Euclid step
// and twice more for the quotients, then three multiplies give l, the left
// term and, with the add or subtract, the numerator.
module fraction_add_subtract
    import fas_pkg::*;
#(
    parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             command,
    input  logic signed [OPERAND_WIDTH-1:0]  left_numerator,
    input  logic signed [OPERAND_WIDTH-1:0]  left_denominator,
    input  logic signed [OPERAND_WIDTH-1:0]  right_numerator,
    input  logic signed [OPERAND_WIDTH-1:0]  right_denominator,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic signed [2*OPERAND_WIDTH:0]  result_numerator,
    output logic signed [2*OPERAND_WIDTH-1:0] result_denominator,
    output logic                             status
);

    fas_cmd_t    cmd;
    fas_status_t stat;

    fas_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    fas_datapath #(.W(OPERAND_WIDTH)) u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .stat               (stat),
        .command            (command),
        .left_numerator     (left_numerator),
        .left_denominator   (left_denominator),
        .right_numerator    (right_numerator),
        .right_denominator  (right_denominator),
        .result_numerator   (result_numerator),
        .result_denominator (result_denominator),
        .status             (status)
    );

endmodule

// ----- hdl/fas_divider.sv -----
module fas_divider
    import fas_pkg::*;
#(
    parameter int W = OPERAND_WIDTH_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic         done,
    output logic [W-1:0] quotient,
    output logic [W-1:0] remainder
);

    localparam int CW = $clog2(W + 1);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [W-1:0]  rem_reg;
    logic [W-1:0]  quo_reg;
    logic [W-1:0]  dsr_reg;
    logic [W:0]    rem_sh;
    logic [W:0]    diff;
    logic [W-1:0]  rem_next;
    logic [W-1:0]  quo_next;

    always_comb
    begin
        rem_sh   = {rem_reg, quo_reg[W-1]};
        diff     = rem_sh - {1'b0, dsr_reg};
        rem_next = diff[W] ? rem_sh[W-1:0] : diff[W-1:0];
        quo_next = {quo_reg[W-2:0], ~diff[W]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// ----- hdl/fas_datapath.sv -----
module fas_datapath
    import fas_pkg::*;
#(
    parameter int W = OPERAND_WIDTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  fas_cmd_t             cmd,
    output fas_status_t          stat,
    input  logic                 command,
    input  logic signed [W-1:0]  left_numerator,
    input  logic signed [W-1:0]  left_denominator,
    input  logic signed [W-1:0]  right_numerator,
    input  logic signed [W-1:0]  right_denominator,
    output logic signed [2*W:0]  result_numerator,
    output logic signed [2*W-1:0] result_denominator,
    output logic                 status
);

    logic                  sub_reg;
    logic signed [W-1:0]   n1_reg, d1_reg, n2_reg, d2_reg;
    logic [W-1:0]          a_reg, b_reg;
    logic                  first_reg, exact_reg;
    logic signed [W:0]     q1_reg, q2_reg;
    logic signed [2*W:0]   t1_reg;
    logic signed [2*W-1:0] l_reg;
    logic signed [2*W:0]   num_reg;
    logic                  status_reg;

    logic [W-1:0]          d1_mag, d2_mag;
    logic [W-1:0]          div_a, div_b, quo, rem;
    logic                  div_done;
    logic                  g_neg, q_neg;
    logic signed [W:0]     q_signed;
    logic signed [W:0]     mul_a, mul_b;
    logic signed [2*W+1:0] prod;

    assign d1_mag = d1_reg[W-1] ? W'(-d1_reg) : W'(d1_reg);
    assign d2_mag = d2_reg[W-1] ? W'(-d2_reg) : W'(d2_reg);
    assign g_neg  = exact_reg & d2_reg[W-1];

    always_comb
    begin
        unique case (cmd.div_sel)
            DIV_GCD:
            begin
                div_a = a_reg;
                div_b = b_reg;
            end
            DIV_Q1:
            begin
                div_a = d1_mag;
                div_b = a_reg;
            end
            default:
            begin
                div_a = d2_mag;
                div_b = a_reg;
            end
        endcase
    end

    fas_divider #(.W(W)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (div_a),
        .divisor   (div_b),
        .done      (div_done),
        .quotient  (quo),
        .remainder (rem)
    );

    always_comb
    begin
        q_neg    = (cmd.q1_latch ? d1_reg[W-1] : d2_reg[W-1]) ^ g_neg;
        q_signed = q_neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
    end

    always_comb
    begin
        unique case (cmd.mul_sel)
            MUL_L:
            begin
                mul_a = (W+1)'(d1_reg);
                mul_b = q2_reg;
            end
            MUL_T1:
            begin
                mul_a = (W+1)'(n1_reg);
                mul_b = q2_reg;
            end
            default:
            begin
                mul_a = (W+1)'(n2_reg);
                mul_b = q1_reg;
            end
        endcase
        prod = mul_a * mul_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg  <= 1'b0;
            exact_reg  <= 1'b0;
            status_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                first_reg <= 1'b1;
                exact_reg <= 1'b0;
            end
            else if (cmd.gcd_step && first_reg)
            begin
                first_reg <= 1'b0;
                exact_reg <= (rem == '0);
            end
            if (cmd.fail)
            begin
                status_reg <= 1'b1;
            end
            else if (cmd.sum)
            begin
                status_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            sub_reg <= command;
            n1_reg  <= left_numerator;
            d1_reg  <= left_denominator;
            n2_reg  <= right_numerator;
            d2_reg  <= right_denominator;
        end
        if (cmd.load)
        begin
            a_reg <= left_denominator[W-1] ? W'(-left_denominator) : W'(left_denominator);
            b_reg <= right_denominator[W-1] ? W'(-right_denominator)
                                            : W'(right_denominator);
        end
        else if (cmd.gcd_step)
        begin
            a_reg <= b_reg;
            b_reg <= rem;
        end
        if (cmd.q1_latch)
        begin
            q1_reg <= q_signed;
        end
        if (cmd.q2_latch)
        begin
            q2_reg <= q_signed;
        end
        if (cmd.mul_en)
        begin
            unique case (cmd.mul_sel)
                MUL_L:   l_reg  <= prod[2*W-1:0];
                MUL_T1:  t1_reg <= prod[2*W:0];
                default: num_reg <= sub_reg ? t1_reg - prod[2*W:0]
                                            : t1_reg + prod[2*W:0];
            endcase
        end
        if (cmd.fail)
        begin
            l_reg   <= '0;
            num_reg <= '0;
        end
    end

    assign stat.den_zero = (d1_reg == '0) || (d2_reg == '0);
    assign stat.b_zero   = (b_reg == '0);
    assign stat.div_done = div_done;

    assign result_numerator   = num_reg;
    assign result_denominator = l_reg;
    assign status             = status_reg;

endmodule

// ----- hdl/fas_ctrl.sv -----
module fas_ctrl
    import fas_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    output logic        out_valid,
    input  logic        out_stall,
    input  fas_status_t stat,
    output fas_cmd_t    cmd
);

    fas_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.div_sel = DIV_GCD;
        cmd.mul_sel = MUL_L;
        in_stall    = 1'b1;
        out_valid   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (stat.den_zero)
                begin
                    cmd.fail   = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_GCD_TEST;
                end
            end
            ST_GCD_TEST:
            begin
                cmd.div_start = 1'b1;
                if (stat.b_zero)
                begin
                    cmd.div_sel = DIV_Q1;
                    state_next  = ST_Q1_WAIT;
                end
                else
                begin
                    state_next = ST_GCD_WAIT;
                end
            end
            ST_GCD_WAIT:
            begin
                if (stat.div_done)
                begin
                    cmd.gcd_step = 1'b1;
                    state_next   = ST_GCD_TEST;
                end
            end
            ST_Q1_WAIT:
            begin
                if (stat.div_done)
                begin
                    cmd.q1_latch  = 1'b1;
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_Q2;
                    state_next    = ST_Q2_WAIT;
                end
            end
            ST_Q2_WAIT:
            begin
                if (stat.div_done)
                begin
                    cmd.q2_latch = 1'b1;
                    state_next   = ST_MUL_L;
                end
            end
            ST_MUL_L:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_L;
                state_next  = ST_MUL_T1;
            end
            ST_MUL_T1:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_T1;
                state_next  = ST_MUL_T2;
            end
            ST_MUL_T2:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_T2;
                state_next  = ST_SUM;
            end
            ST_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                out_valid = 1'b1;
                if (!out_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- sim/tb_top.sv -----
module tb_top;
    import fas_pkg::*;

    localparam int W = OPERAND_WIDTH_DEF;
    localparam int CYCLE_LIMIT = 2000000;

    typedef struct {
        logic         sub;
        logic [W-1:0] n1;
        logic [W-1:0] d1;
        logic [W-1:0] n2;
        logic [W-1:0] d2;
    } fraction_pair_t;

    typedef struct {
        logic [2*W:0]   num;
        logic [2*W-1:0] den;
        logic           err;
    } fraction_sum_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic command;
    logic signed [W-1:0] left_numerator;
    logic signed [W-1:0] left_denominator;
    logic signed [W-1:0] right_numerator;
    logic signed [W-1:0] right_denominator;
    logic out_valid;
    logic out_stall;
    logic signed [2*W:0] result_numerator;
    logic signed [2*W-1:0] result_denominator;
    logic status;

    fraction_pair_t pending_pairs[$];
    fraction_sum_t  expected_sums[$];
    int  error_count;
    int  cycle_count;
    bit  stimulus_done;
    bit  calm;

    fraction_add_subtract u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .command(command),
        .left_numerator(left_numerator), .left_denominator(left_denominator),
        .right_numerator(right_numerator), .right_denominator(right_denominator),
        .out_valid(out_valid), .out_stall(out_stall),
        .result_numerator(result_numerator), .result_denominator(result_denominator),
        .status(status)
    );

    function automatic fraction_sum_t combine_fractions(fraction_pair_t p);
        fraction_sum_t r;
        longint n1, d1, n2, d2, a, b, k, rem, g, l, t1, t2, s;
        n1 = longint'($signed(p.n1));
        d1 = longint'($signed(p.d1));
        n2 = longint'($signed(p.n2));
        d2 = longint'($signed(p.d2));
        r.num = '0;
        r.den = '0;
        r.err = 1'b0;
        if (d1 == 0 || d2 == 0)
        begin
            r.err = 1'b1;
            return r;
        end
        a = d1;
        b = d2;
        while (b != 0)
        begin
            k = b;
            rem = a % b;
            b = (rem < 0) ? -rem : rem;
            a = k;
        end
        g = a;
        l = (d1 * d2) / g;
        t1 = n1 * (l / d1);
        t2 = n2 * (l / d2);
        s = p.sub ? (t1 - t2) : (t1 + t2);
        r.num = s[2*W:0];
        r.den = l[2*W-1:0];
        return r;
    endfunction

    function automatic logic [W-1:0] pick_operand();
        case ($urandom_range(0, 9))
            0: return {1'b1, {(W-1){1'b0}}};
            1: return {1'b0, {(W-1){1'b1}}};
            2: return '0;
            3, 4: return W'($urandom_range(0, 24)) - W'(12);
            5: return W'($urandom_range(1, 8)) * W'($urandom_range(1, 8)) * W'(6);
            default: return W'($urandom);
        endcase
    endfunction

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #2 clk = ~clk;
        end
    end

    initial
    begin
        fraction_pair_t p;
        logic [W-1:0] edge_vals[6];
        edge_vals = '{{1'b1, {(W-1){1'b0}}}, {1'b0, {(W-1){1'b1}}}, '1, W'(1), W'(0), W'(6)};
        rst_n = 1'b0;
        for (int i = 0; i < 24; i++)
        begin
            p.sub = i[0];
            p.n1 = edge_vals[i % 6];
            p.d1 = edge_vals[(i / 2) % 6];
            p.n2 = edge_vals[(i + 3) % 6];
            p.d2 = edge_vals[(i / 4) % 6];
            pending_pairs.push_back(p);
        end
        // d2 negative and dividing d1, plus a zero left denominator
        p = '{1'b0, W'(5), W'(12), W'(7), -W'(4)};
        pending_pairs.push_back(p);
        p = '{1'b1, W'(5), W'(0), W'(7), W'(3)};
        pending_pairs.push_back(p);
        for (int i = 0; i < 900; i++)
        begin
            p.sub = $urandom_range(0, 1);
            p.n1 = pick_operand();
            p.d1 = pick_operand();
            p.n2 = pick_operand();
            p.d2 = pick_operand();
            pending_pairs.push_back(p);
        end
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    initial
    begin
        in_valid = 1'b0;
        out_stall = 1'b0;
        command = 1'b0;
        left_numerator = '0;
        left_denominator = '0;
        right_numerator = '0;
        right_denominator = '0;
        error_count = 0;
        cycle_count = 0;
        stimulus_done = 1'b0;
        calm = 1'b0;
    end

    always @(negedge clk)
    begin
        fraction_pair_t p;
        calm <= (cycle_count > 20000 && cycle_count < 40000);
        out_stall <= rst_n && !calm && ($urandom_range(0, 99) < 27);
        if (rst_n && !(in_valid && in_stall))
        begin
            if (pending_pairs.size() > 0 && (calm || $urandom_range(0, 99) >= 27))
            begin
                p = pending_pairs.pop_front();
                in_valid <= 1'b1;
                command <= p.sub;
                left_numerator <= p.n1;
                left_denominator <= p.d1;
                right_numerator <= p.n2;
                right_denominator <= p.d2;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        fraction_pair_t p;
        fraction_sum_t e;
        int bad;
        bad = 0;
        cycle_count <= cycle_count + 1;
        if (rst_n && in_valid && !in_stall)
        begin
            p = '{command, left_numerator, left_denominator,
                  right_numerator, right_denominator};
            expected_sums.push_back(combine_fractions(p));
        end
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_sums.size() == 0)
            begin
                $display("%0t: result with none expected, actual %0d/%0d status %0d",
                         $time, result_numerator, result_denominator, status);
                bad = bad + 1;
            end
            else
            begin
                e = expected_sums.pop_front();
                if (result_numerator !== e.num)
                begin
                    $display("%0t: numerator expected %0d actual %0d", $time,
                             $signed(e.num), result_numerator);
                    bad = bad + 1;
                end
                if (result_denominator !== e.den)
                begin
                    $display("%0t: denominator expected %0d actual %0d", $time,
                             $signed(e.den), result_denominator);
                    bad = bad + 1;
                end
                if (status !== e.err)
                begin
                    $display("%0t: status expected %0d actual %0d", $time, e.err, status);
                    bad = bad + 1;
                end
            end
        end
        if (bad != 0)
        begin
            error_count <= error_count + bad;
        end
    end

    initial
    begin
        @(posedge rst_n);
        while (!(pending_pairs.size() == 0 && !in_valid && expected_sums.size() == 0)
               && cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
        end
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("fraction_add_subtract verification failed");
        end
        else
        begin
            repeat (250) @(posedge clk);
            if (error_count == 0 && expected_sums.size() == 0)
            begin
                $display("fraction_add_subtract verification clean");
            end
            else
            begin
                $display("fraction_add_subtract verification failed");
            end
        end
        $finish;
    end

endmodule
